// ----- src/ancestor_likelihood_combine_assert.svh -----
// ---------------------------------------------------------------------------
// ancestor_likelihood_combine_assert.svh
// assertion macros for the ancestor likelihood combine block
// ---------------------------------------------------------------------------
`ifndef ANCESTOR_LIKELIHOOD_COMBINE_ASSERT_SVH
`define ANCESTOR_LIKELIHOOD_COMBINE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, sampled on i_clk, off during reset
`define ALC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ALC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ALC_ASSERT_IMP(lbl, ante, cons)
`define ALC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- src/alc_pkg.sv -----
// ---------------------------------------------------------------------------
// alc_pkg
// shared types, constants and table builder for the likelihood combine block
// ---------------------------------------------------------------------------
`default_nettype none

package alc_pkg;

    localparam int NUM_MATRICES = 1024;
    localparam int IDX_W        = $clog2(NUM_MATRICES);
    localparam int E_W          = 25;
    localparam int REST_W       = 23;
    localparam int TBL_W        = E_W + REST_W;
    localparam int MUL_A_W      = 35;
    localparam int MUL_B_W      = 32;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT_LEN  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_LEN = 2'd1;

    localparam logic [31:0] QUARTER  = 32'h0040_0000;
    localparam logic [34:0] TINY_SUM = 35'd168;
    localparam logic [34:0] NORM_SUM = 35'h0040_0000;

    typedef logic [TBL_W-1:0] t_table [NUM_MATRICES];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IDXL,
        ST_IDXR,
        ST_ROML,
        ST_ROMR,
        ST_TRL,
        ST_BASR,
        ST_TRR,
        ST_PRD,
        ST_PLST,
        ST_SUM,
        ST_NORM,
        ST_FIN
    } t_state;

    // restoring long division, only used while the table is built
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        logic [64:0]     rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^-d in Q24 for table entry idx, from a truncated Taylor sum of e^d
    function automatic longint unsigned exp_neg_q24(input int idx);
        longint unsigned num;
        longint unsigned term;
        longint unsigned sum;
        num  = 64'(2 * (idx + 1));
        term = 64'd1 << 36;
        sum  = term;
        for (int kk = 1; kk < 64; kk++) begin
            if (term != 64'd0) begin
                term = udiv64(term * num, 64'(NUM_MATRICES) * 64'(kk));
                sum  = sum + term;
            end
        end
        return udiv64((64'd1 << 60) + (sum >> 1), sum);
    endfunction

    // entry holds {e, rest}; diag - rest equals e
    function automatic t_table build_table();
        t_table          tbl;
        longint unsigned e;
        longint unsigned rest;
        for (int i = 0; i < NUM_MATRICES; i++) begin
            e = exp_neg_q24(i);
            if (e > (64'd1 << 24)) begin
                e = 64'd1 << 24;
            end
            rest   = udiv64((64'd1 << 24) - e + 64'd2, 64'd5);
            tbl[i] = {e[E_W-1:0], rest[REST_W-1:0]};
        end
        return tbl;
    endfunction

    // round a Q48 value back to Q24 and saturate to 32 bits
    function automatic logic [31:0] round_sat(input logic [PROD_W:0] x);
        logic [PROD_W+1:0] t;
        t = {1'b0, x} + (PROD_W+2)'(24'h80_0000);
        if (|t[PROD_W+1:56]) begin
            return 32'hFFFF_FFFF;
        end
        return t[55:24];
    endfunction

endpackage

`default_nettype wire

// ----- src/alc_mul.sv -----
// ---------------------------------------------------------------------------
// alc_mul
// shared unsigned multiplier with a registered product
// ---------------------------------------------------------------------------
`default_nettype none

module alc_mul (
    input  wire logic                         i_clk,
    input  wire logic [alc_pkg::MUL_A_W-1:0]  i_a,
    input  wire logic [alc_pkg::MUL_B_W-1:0]  i_b,
    output logic      [alc_pkg::PROD_W-1:0]   o_prod
);

    // one product per cycle, result in the next cycle
    always_ff @(posedge i_clk) begin
        o_prod <= alc_pkg::PROD_W'(i_a) * alc_pkg::PROD_W'(i_b);
    end

endmodule

`default_nettype wire

// ----- src/alc_rom.sv -----
// ---------------------------------------------------------------------------
// alc_rom
// substitution matrix table, e and rest per distance step, registered read
// ---------------------------------------------------------------------------
`default_nettype none

module alc_rom (
    input  wire logic                        i_clk,
    input  wire logic [alc_pkg::IDX_W-1:0]   i_addr,
    output logic      [alc_pkg::TBL_W-1:0]   o_data
);

    localparam alc_pkg::t_table Rom = alc_pkg::build_table();

    // synchronous read
    always_ff @(posedge i_clk) begin
        o_data <= Rom[i_addr];
    end

endmodule

`default_nettype wire

// ----- src/ancestor_likelihood_combine.sv -----
// Columns are worked one at a time: the input stalls from an accepted beat until
// the result beat; nineteen products pass one shared multiplier, and
// renormalization scales by four once per cycle.
// The input side is free again as soon as the result is in the output register.
// Reset (synchronous, active low) clears the sequencer, output valid and both
// branch length registers and stalls the input; the matrix table is constant.
// ---------------------------------------------------------------------------
// ancestor_likelihood_combine
// per-column node combine of two child five-state likelihood vectors
// ---------------------------------------------------------------------------
`default_nettype none

`include "ancestor_likelihood_combine_assert.svh"

module ancestor_likelihood_combine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [31:0]        i_left_a,
    input  wire logic [31:0]        i_left_c,
    input  wire logic [31:0]        i_left_g,
    input  wire logic [31:0]        i_left_t,
    input  wire logic [31:0]        i_left_gap,
    input  wire logic [31:0]        i_right_a,
    input  wire logic [31:0]        i_right_c,
    input  wire logic [31:0]        i_right_g,
    input  wire logic [31:0]        i_right_t,
    input  wire logic [31:0]        i_right_gap,
    input  wire logic [15:0]        i_column_rate,
    input  wire logic signed [20:0] i_scale_sum,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [31:0]             o_anc_a,
    output logic [31:0]             o_anc_c,
    output logic [31:0]             o_anc_g,
    output logic [31:0]             o_anc_t,
    output logic [31:0]             o_anc_gap,
    output logic signed [20:0]      o_anc_scale
);

    localparam int PW = alc_pkg::PROD_W;

    alc_pkg::t_state r_state, n_state;
    logic [2:0]      r_k, n_k;

    logic [23:0]        r_len_l, r_len_r;
    logic [31:0]        r_lv [5];
    logic [31:0]        r_rv [5];
    logic [31:0]        r_lt [5];
    logic [31:0]        r_rt [5];
    logic [31:0]        r_p  [5];
    logic [15:0]        r_rate;
    logic signed [22:0] r_scale;
    logic [34:0]        r_sum_l, r_sum_r, r_psum;
    logic [alc_pkg::E_W-1:0]    r_e_l, r_e_r;
    logic [alc_pkg::REST_W-1:0] r_rest_l, r_rest_r;
    logic [PW-1:0]      r_base;
    logic               r_out_valid;

    logic [alc_pkg::MUL_A_W-1:0] mul_a;
    logic [alc_pkg::MUL_B_W-1:0] mul_b;
    logic [PW-1:0]               mul_prod;
    logic [alc_pkg::IDX_W-1:0]   rom_addr;
    logic [alc_pkg::TBL_W-1:0]   rom_data;
    logic [15:0]                 idx_raw;
    logic [31:0]                 tr_val;
    logic [31:0]                 pr_val;
    logic                        in_acc;
    logic                        out_free;
    logic                        k_last;

    alc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    alc_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign k_last   = (r_k == 3'd4);

    // matrix index, clamped to the last table entry
    assign idx_raw  = mul_prod[39:24];
    always_comb begin
        if (idx_raw > 16'(alc_pkg::NUM_MATRICES - 1)) begin
            rom_addr = alc_pkg::IDX_W'(alc_pkg::NUM_MATRICES - 1);
        end else begin
            rom_addr = idx_raw[alc_pkg::IDX_W-1:0];
        end
    end

    // transformed element and rounded product from the multiplier output
    assign tr_val = alc_pkg::round_sat({1'b0, mul_prod} + {1'b0, r_base});
    assign pr_val = alc_pkg::round_sat({1'b0, mul_prod});

    // next state
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            alc_pkg::ST_IDLE: if (in_acc) n_state = alc_pkg::ST_IDXL;
            alc_pkg::ST_IDXL: n_state = alc_pkg::ST_IDXR;
            alc_pkg::ST_IDXR: n_state = alc_pkg::ST_ROML;
            alc_pkg::ST_ROML: n_state = alc_pkg::ST_ROMR;
            alc_pkg::ST_ROMR: begin
                n_state = alc_pkg::ST_TRL;
                n_k     = 3'd0;
            end
            alc_pkg::ST_TRL: begin
                n_k = r_k + 3'd1;
                if (k_last) begin
                    n_state = alc_pkg::ST_BASR;
                    n_k     = 3'd0;
                end
            end
            alc_pkg::ST_BASR: n_state = alc_pkg::ST_TRR;
            alc_pkg::ST_TRR: begin
                n_k = r_k + 3'd1;
                if (k_last) begin
                    n_state = alc_pkg::ST_PRD;
                    n_k     = 3'd0;
                end
            end
            alc_pkg::ST_PRD: begin
                n_k = r_k + 3'd1;
                if (k_last) begin
                    n_state = alc_pkg::ST_PLST;
                    n_k     = 3'd0;
                end
            end
            alc_pkg::ST_PLST: n_state = alc_pkg::ST_SUM;
            alc_pkg::ST_SUM:  n_state = alc_pkg::ST_NORM;
            alc_pkg::ST_NORM: begin
                if (r_psum < alc_pkg::TINY_SUM || r_psum >= alc_pkg::NORM_SUM) begin
                    n_state = alc_pkg::ST_FIN;
                end
            end
            alc_pkg::ST_FIN: if (out_free) n_state = alc_pkg::ST_IDLE;
            default: n_state = alc_pkg::ST_IDLE;
        endcase
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            alc_pkg::ST_IDXL: begin
                mul_a = 35'(r_rate);
                mul_b = 32'(r_len_l);
            end
            alc_pkg::ST_IDXR: begin
                mul_a = 35'(r_rate);
                mul_b = 32'(r_len_r);
            end
            alc_pkg::ST_ROMR: begin
                mul_a = r_sum_l;
                mul_b = 32'(r_rest_l);
            end
            alc_pkg::ST_TRL: begin
                mul_a = 35'(r_lv[r_k]);
                mul_b = 32'(r_e_l);
            end
            alc_pkg::ST_BASR: begin
                mul_a = r_sum_r;
                mul_b = 32'(r_rest_r);
            end
            alc_pkg::ST_TRR: begin
                mul_a = 35'(r_rv[r_k]);
                mul_b = 32'(r_e_r);
            end
            alc_pkg::ST_PRD: begin
                mul_a = 35'(r_lt[r_k]);
                mul_b = r_rt[r_k];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // busy while a column is in work, and held off during reset
    assign o_in_stall = !i_rst_n || (r_state != alc_pkg::ST_IDLE);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alc_pkg::ST_IDLE;
            r_k         <= 3'd0;
            r_out_valid <= 1'b0;
            r_len_l     <= '0;
            r_len_r     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (r_state == alc_pkg::ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == alc_pkg::CFG_LEFT_LEN) begin
                    r_len_l <= i_cfg_data;
                end else if (i_cfg_idx == alc_pkg::CFG_RIGHT_LEN) begin
                    r_len_r <= i_cfg_data;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            alc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_lv[0] <= i_left_a;
                    r_lv[1] <= i_left_c;
                    r_lv[2] <= i_left_g;
                    r_lv[3] <= i_left_t;
                    r_lv[4] <= i_left_gap;
                    r_rv[0] <= i_right_a;
                    r_rv[1] <= i_right_c;
                    r_rv[2] <= i_right_g;
                    r_rv[3] <= i_right_t;
                    r_rv[4] <= i_right_gap;
                    r_rate  <= i_column_rate;
                    r_scale <= 23'(i_scale_sum);
                end
            end
            alc_pkg::ST_IDXL: begin
                r_sum_l <= 35'(r_lv[0]) + 35'(r_lv[1]) + 35'(r_lv[2])
                         + 35'(r_lv[3]) + 35'(r_lv[4]);
                r_sum_r <= 35'(r_rv[0]) + 35'(r_rv[1]) + 35'(r_rv[2])
                         + 35'(r_rv[3]) + 35'(r_rv[4]);
            end
            alc_pkg::ST_ROML: begin
                r_e_l    <= rom_data[alc_pkg::TBL_W-1:alc_pkg::REST_W];
                r_rest_l <= rom_data[alc_pkg::REST_W-1:0];
            end
            alc_pkg::ST_ROMR: begin
                r_e_r    <= rom_data[alc_pkg::TBL_W-1:alc_pkg::REST_W];
                r_rest_r <= rom_data[alc_pkg::REST_W-1:0];
            end
            // left side: first the shared sum term, then one element per cycle
            alc_pkg::ST_TRL: begin
                if (r_k == 3'd0) begin
                    r_base <= mul_prod;
                end else begin
                    r_lt[r_k - 3'd1] <= tr_val;
                end
            end
            alc_pkg::ST_BASR: r_lt[4] <= tr_val;
            alc_pkg::ST_TRR: begin
                if (r_k == 3'd0) begin
                    r_base <= mul_prod;
                end else begin
                    r_rt[r_k - 3'd1] <= tr_val;
                end
            end
            alc_pkg::ST_PRD: begin
                if (r_k == 3'd0) begin
                    r_rt[4] <= tr_val;
                end else begin
                    r_p[r_k - 3'd1] <= pr_val;
                end
            end
            alc_pkg::ST_PLST: r_p[4] <= pr_val;
            alc_pkg::ST_SUM: begin
                r_psum <= 35'(r_p[0]) + 35'(r_p[1]) + 35'(r_p[2])
                        + 35'(r_p[3]) + 35'(r_p[4]);
            end
            // renormalize: flat quarter for a vanishing column, else x4 steps
            alc_pkg::ST_NORM: begin
                if (r_psum < alc_pkg::TINY_SUM) begin
                    for (int j = 0; j < 5; j++) begin
                        r_p[j] <= alc_pkg::QUARTER;
                    end
                    r_scale <= r_scale - 23'sd5;
                end else if (r_psum < alc_pkg::NORM_SUM) begin
                    for (int j = 0; j < 5; j++) begin
                        r_p[j] <= {r_p[j][29:0], 2'b00};
                    end
                    r_psum  <= {r_psum[32:0], 2'b00};
                    r_scale <= r_scale - 23'sd2;
                end
            end
            // load the output register with a saturated scale
            alc_pkg::ST_FIN: begin
                if (out_free) begin
                    o_anc_a   <= r_p[0];
                    o_anc_c   <= r_p[1];
                    o_anc_g   <= r_p[2];
                    o_anc_t   <= r_p[3];
                    o_anc_gap <= r_p[4];
                    if (r_scale < -23'sd1048576) begin
                        o_anc_scale <= -21'sd1048576;
                    end else begin
                        o_anc_scale <= r_scale[20:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `ALC_ASSERT_NXT(a_accept_starts, in_acc, r_state == alc_pkg::ST_IDXL)
    `ALC_ASSERT_NXT(a_fin_loads, r_state == alc_pkg::ST_FIN && out_free, o_out_valid)
    `ALC_ASSERT_IMP(a_k_range, 1'b1, r_k <= 3'd4)

endmodule

`default_nettype wire
